[rtl/pcx_pkg.sv]
// Shared types and constants for the PCX run-length decoder.
package pcx_pkg;

	localparam int PIXEL_COUNT_BITS = 21;
	localparam int HDR_LEN_BITS     = 8;
	localparam int RUN_COUNT_BITS   = 6;
	localparam int CFG_INDEX_BITS   = 2;
	localparam int CFG_DATA_BITS    = PIXEL_COUNT_BITS;

	localparam logic [7:0] RUN_FLAG_MASK  = 8'hC0;
	localparam logic [7:0] RUN_COUNT_MASK = 8'h3F;

	localparam logic [HDR_LEN_BITS-1:0]     HDR_LEN_RESET     = HDR_LEN_BITS'(128);
	localparam logic [PIXEL_COUNT_BITS-1:0] PIXEL_TOTAL_RESET = PIXEL_COUNT_BITS'(400 * 256);

	localparam int CMD_DEPTH    = 4;
	localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);

	localparam logic [CFG_INDEX_BITS-1:0] REG_HEADER_LENGTH = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_TOTAL   = CFG_INDEX_BITS'(1);

	// One decoded job for the back end: a restart mark and a run of one value.
	typedef struct packed {
		logic                      restart;
		logic [7:0]                value;
		logic [RUN_COUNT_BITS-1:0] count;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic complete;
		logic emit;
	} back_status_t;

endpackage

[rtl/pcx_front.sv]
// Front end: header skip and run/literal classification of file bytes.
module pcx_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic [7:0]                        data_byte,
	input  logic                              first_byte,
	input  logic [pcx_pkg::HDR_LEN_BITS-1:0]  header_length,
	output logic                              cmd_push,
	output pcx_pkg::cmd_t                     cmd
);
	import pcx_pkg::*;

	logic [HDR_LEN_BITS-1:0]   hdr_left_q, hdr_left_d, hdr_eff;
	logic                      awaiting_q, awaiting_d, awaiting_eff;
	logic [RUN_COUNT_BITS-1:0] run_count_q, run_count_d, run_count_eff;

	always_comb begin
		hdr_eff       = first_byte ? header_length : hdr_left_q;
		awaiting_eff  = first_byte ? 1'b0 : awaiting_q;
		run_count_eff = first_byte ? '0 : run_count_q;

		hdr_left_d  = hdr_eff;
		awaiting_d  = awaiting_eff;
		run_count_d = run_count_eff;

		cmd.restart = first_byte;
		cmd.value   = data_byte;
		cmd.count   = '0;

		priority if (hdr_eff != '0) begin
			hdr_left_d = hdr_eff - 1'b1;
		end else if (awaiting_eff) begin
			cmd.count   = run_count_eff;
			awaiting_d  = 1'b0;
			run_count_d = '0;
		end else if ((data_byte & RUN_FLAG_MASK) == RUN_FLAG_MASK) begin
			run_count_d = RUN_COUNT_BITS'(data_byte & RUN_COUNT_MASK);
			awaiting_d  = 1'b1;
		end else begin
			cmd.count = RUN_COUNT_BITS'(1);
		end

		// a restart always goes through so the back end clears its counters
		cmd_push = accept && (cmd.restart || cmd.count != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_left_q  <= '0;
			awaiting_q  <= 1'b0;
			run_count_q <= '0;
		end else if (accept) begin
			hdr_left_q  <= hdr_left_d;
			awaiting_q  <= awaiting_d;
			run_count_q <= run_count_d;
		end
	end

endmodule

[rtl/pcx_cmd_fifo.sv]
// Short command queue between the front and back ends.
module pcx_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  pcx_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output pcx_pkg::cmd_t rd_cmd
);
	import pcx_pkg::*;

	cmd_t                    mem_q [CMD_DEPTH];
	logic [CMD_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMD_PTR_BITS:0]   level_q;
	logic                    do_wr, do_rd;

	assign full     = (level_q == (CMD_PTR_BITS+1)'(CMD_DEPTH));
	assign rd_valid = (level_q != '0);
	assign rd_cmd   = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

[rtl/pcx_back.sv]
// Back end: expands runs into pixels, clips at the pixel total, holds the output word.
module pcx_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [pcx_pkg::PIXEL_COUNT_BITS-1:0] pixel_total,
	input  logic                                 cmd_valid,
	input  pcx_pkg::cmd_t                        cmd,
	output logic                                 cmd_pop,
	input  logic                                 pop,
	output logic                                 empty,
	output logic [7:0]                           pixel_value,
	output logic                                 last_pixel,
	output pcx_pkg::back_status_t                status
);
	import pcx_pkg::*;

	logic [RUN_COUNT_BITS-1:0]   left_q;
	logic [7:0]                  value_q;
	logic [PIXEL_COUNT_BITS-1:0] emitted_q, emitted_inc;
	logic                        complete_q;
	logic                        out_valid_q, out_last_q;
	logic [7:0]                  out_value_q;

	logic active, stop, slot_free, emit, drop, is_last, finish;

	always_comb begin
		active      = (left_q != '0);
		stop        = complete_q || (emitted_q >= pixel_total);
		slot_free   = !out_valid_q || pop;
		emitted_inc = emitted_q + 1'b1;
		is_last     = (emitted_inc == pixel_total);
		drop        = active && stop;
		emit        = active && !stop && slot_free;
		finish      = drop || (emit && (is_last || left_q == RUN_COUNT_BITS'(1)));
		cmd_pop     = cmd_valid && (!active || finish);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			emitted_q   <= '0;
			complete_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// a load only happens with no run active or as the current run ends, so it takes precedence
			if (cmd_pop) begin
				left_q <= cmd.count;
			end else if (drop || (emit && is_last)) begin
				left_q <= '0;
			end else if (emit) begin
				left_q <= left_q - 1'b1;
			end
			if (cmd_pop && cmd.restart) begin
				emitted_q  <= '0;
				complete_q <= 1'b0;
			end else if (emit) begin
				emitted_q <= emitted_inc;
				if (is_last) begin
					complete_q <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			value_q <= cmd.value;
		end
		if (emit) begin
			out_value_q <= value_q;
			out_last_q  <= is_last;
		end
	end

	assign empty           = !out_valid_q;
	assign pixel_value     = out_value_q;
	assign last_pixel      = out_last_q;
	assign status.active   = active;
	assign status.complete = complete_q;
	assign status.emit     = emit;

endmodule

[rtl/pcx_rle_decoder.sv]
// Top level of the PCX run-length decoder: config registers, front, queue, back.
// Path: with the back end idle, a byte's command is written into the queue, then loaded
// into the back end's run registers, then its pixel word is registered onto the result ports.
// Throughput: one input byte a cycle while the queue has room; a run of n pixels
// occupies the back end, one pixel per cycle while the output register is free or popped.
// Reset: header_length 128, pixel_total 102400, queue and output empty, and every
// byte is discarded until one arrives with first_byte set.
module pcx_rle_decoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [7:0]                           data_byte,
	input  logic                                 first_byte,
	output logic                                 empty,
	input  logic                                 pop,
	output logic [7:0]                           pixel_value,
	output logic                                 last_pixel,
	input  logic                                 cfg_write,
	input  logic [pcx_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [pcx_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import pcx_pkg::*;

	logic [HDR_LEN_BITS-1:0]     header_length_q;
	logic [PIXEL_COUNT_BITS-1:0] pixel_total_q;

	logic         accept;
	logic         cmd_push, cmd_valid, cmd_pop;
	cmd_t         cmd_in, cmd_out;
	back_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_length_q <= HDR_LEN_RESET;
			pixel_total_q   <= PIXEL_TOTAL_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_HEADER_LENGTH: header_length_q <= cfg_data[HDR_LEN_BITS-1:0];
				REG_PIXEL_TOTAL:   pixel_total_q   <= cfg_data[PIXEL_COUNT_BITS-1:0];
				default:           ;
			endcase
		end
	end

	assign accept = push && !full;

	pcx_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.header_length (header_length_q),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in)
	);

	pcx_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_cmd   (cmd_in),
		.full     (full),
		.rd_en    (cmd_pop),
		.rd_valid (cmd_valid),
		.rd_cmd   (cmd_out)
	);

	pcx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_total (pixel_total_q),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd_out),
		.cmd_pop     (cmd_pop),
		.pop         (pop),
		.empty       (empty),
		.pixel_value (pixel_value),
		.last_pixel  (last_pixel),
		.status      (status)
	);

	a_full_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> cmd_valid)
		else $error("queue full with no command readable");

	a_no_emit_when_complete: assert property (@(posedge clk) disable iff (!arst_n)
		status.complete |-> !status.emit)
		else $error("pixel emitted after image completion");

	a_emit_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		status.emit |-> status.active)
		else $error("pixel emitted with no run in progress");

	a_new_word_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		status.emit |=> !empty)
		else $error("emitted pixel missing from output register");

endmodule
